// ===== design/signed_integer_alu_unit_assert.svh =====
// assertion macros shared by the signed integer alu unit
// no dependencies
`ifndef SIGNED_INTEGER_ALU_UNIT_ASSERT_SVH
`define SIGNED_INTEGER_ALU_UNIT_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define SIA_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define SIA_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== design/sia_pkg.sv =====
// package for the signed integer alu unit: operation codes
// no dependencies
`timescale 1ns / 1ps

package sia_pkg;
    localparam int OP_WIDTH = 4;
    typedef logic [OP_WIDTH-1:0] t_op;
    localparam t_op OP_ADD  = 4'd0;
    localparam t_op OP_SUB  = 4'd1;
    localparam t_op OP_MUL  = 4'd2;
    localparam t_op OP_DIV  = 4'd3;
    localparam t_op OP_LT   = 4'd4;
    localparam t_op OP_LE   = 4'd5;
    localparam t_op OP_GT   = 4'd6;
    localparam t_op OP_GE   = 4'd7;
    localparam t_op OP_ABS  = 4'd8;
    localparam t_op OP_ZERO = 4'd9;
endpackage

// ===== design/signed_integer_alu_unit.sv =====
// signed integer alu unit: pipelined add/sub/mul/abs/compare and restoring divider
// depends on sia_pkg and signed_integer_alu_unit_assert.svh
//
// channel | dir | tdata fields (low bit up)                        | tuser
// s_axis  | in  | operand_a[W], operand_b[W], pad to bytes          | op[4]
// m_axis  | out | value[W], remainder[W], flag, div_by_zero, pad    | none
//
// one beat per cycle while m_axis is not stalled; one quotient bit per
// divider stage, plus prep, pass-through and output (sign-fix) stages.
// the multiplier is split over the prep and first stage.
// reset clears stage valid bits only.
// a stall at m_axis holds the whole pipeline; s_axis_tready follows it.
`timescale 1ns / 1ps

`include "signed_integer_alu_unit_assert.svh"

module signed_integer_alu_unit #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // operand_a, operand_b
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // op
    input  sia_pkg::t_op            s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // value, remainder, flag, div_by_zero
    output logic [((2*DATA_WIDTH+2+7)/8)*8-1:0] m_axis_tdata
);
    import sia_pkg::*;

    localparam int W      = DATA_WIDTH;
    localparam int NST    = W + 2;
    localparam int OUT_W  = ((2*W+2+7)/8)*8;
    localparam int HW     = (W+1)/2;

    typedef struct packed {
        t_op          op;
        logic         neg_q;
        logic         neg_r;
        logic         dz;
        logic [W-1:0] quo;
        logic [W-1:0] rem;
        logic [W-1:0] num;
        logic [W-1:0] den;
        logic [W-1:0] res;
        logic         flag;
    } t_stage;

    logic   adv;
    logic   [NST-1:0] r_vld;
    t_stage r_st [NST];
    t_stage n_st [NST];
    logic [W-1:0] r_mlo, r_mhi;
    logic [W-1:0] r_out_v, r_out_r;
    logic         r_out_f, r_out_z, r_out_vld;

    assign adv = !r_out_vld || m_axis_tready;
    assign s_axis_tready = adv;

    logic signed [W-1:0] a, b;
    assign a = s_axis_tdata[W-1:0];
    assign b = s_axis_tdata[2*W-1:W];

    always_comb begin
        logic lt, gt;
        n_st[0] = '0;
        lt = a < b;
        gt = b < a;
        n_st[0].op    = s_axis_tuser;
        n_st[0].neg_q = a[W-1] ^ b[W-1];
        n_st[0].neg_r = a[W-1];
        n_st[0].dz    = (b == '0);
        n_st[0].num   = a[W-1] ? W'(-a) : a;
        n_st[0].den   = b[W-1] ? W'(-b) : b;
        case (s_axis_tuser)
            OP_ADD:  n_st[0].res = W'(a + b);
            OP_SUB:  n_st[0].res = W'(a - b);
            OP_ABS:  n_st[0].res = a[W-1] ? W'(-a) : a;
            OP_LT:   n_st[0].flag = lt;
            OP_LE:   n_st[0].flag = !gt;
            OP_GT:   n_st[0].flag = gt;
            OP_GE:   n_st[0].flag = !lt;
            OP_ZERO: n_st[0].flag = (a == '0);
            default: n_st[0].res = '0;
        endcase
    end

    // multiplier: low-half and high-half partial products of b
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mlo <= W'(a * W'(b[HW-1:0]));
            r_mhi <= W'(a * W'(b[W-1:HW]));
        end
    end

    // divider stages: stage k produces quotient bit W-k
    for (genvar k = 1; k <= W; k++) begin : g_div
        always_comb begin
            logic [W:0] trial;
            n_st[k] = r_st[k-1];
            trial = {r_st[k-1].rem, r_st[k-1].num[W-k]};
            if (trial >= {1'b0, r_st[k-1].den}) begin
                n_st[k].rem = W'(trial - {1'b0, r_st[k-1].den});
                n_st[k].quo[W-k] = 1'b1;
            end else begin
                n_st[k].rem = trial[W-1:0];
            end
            if (k == 1 && r_st[0].op == OP_MUL) begin
                n_st[k].res = W'(r_mlo + (r_mhi << HW));
            end
        end
    end

    always_comb begin
        n_st[NST-1] = r_st[NST-2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_vld <= {r_vld[NST-2:0], s_axis_tvalid};
            r_out_vld <= r_vld[NST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < NST; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    // sign fix and result select
    always_ff @(posedge i_clk) begin
        t_stage s;
        s = r_st[NST-1];
        if (adv) begin
            r_out_v <= s.res;
            r_out_r <= '0;
            r_out_f <= s.flag;
            r_out_z <= 1'b0;
            if (s.op == OP_DIV) begin
                if (s.dz) begin
                    r_out_v <= '0;
                    r_out_z <= 1'b1;
                end else begin
                    r_out_v <= s.neg_q ? W'(-s.quo) : s.quo;
                    r_out_r <= s.neg_r ? W'(-s.rem) : s.rem;
                end
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OUT_W'({r_out_z, r_out_f, r_out_r, r_out_v});

    `SIA_ASSERT_IMPL(a_dz_zero, i_clk, i_rst_n, m_axis_tvalid && r_out_z, r_out_v == '0 && r_out_r == '0, "div by zero with nonzero result")
    `SIA_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output changed under stall")
    `SIA_ASSERT_IMPL(a_ready, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready, "not ready while output empty")
endmodule
